// ===== src/ptgb_pkg.sv =====
// Shared types, constants and helpers for the planar tile glyph blitter.
package ptgb_pkg;

    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAX_GLYPH_HEIGHT = 16;
    localparam int MAX_WRITES       = 8;
    localparam int CNT_W            = $clog2(MAX_WRITES + 1);

    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    localparam logic [2:0] CFG_BASE_ADDRESS   = 3'd0;
    localparam logic [2:0] CFG_ROW_STRIDE     = 3'd1;
    localparam logic [2:0] CFG_COLUMN_STRIDE  = 3'd2;
    localparam logic [2:0] CFG_COLUMN_SHIFT   = 3'd3;
    localparam logic [2:0] CFG_BYTES_PER_LINE = 3'd4;

    typedef struct packed {
        logic load_hdr;
        logic calc_mul;
        logic calc_sum;
        logic load_byte;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic glyph_active;
        logic chunk_ok;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] low_mask(input logic [3:0] n);
        logic [8:0] v;
        begin
            v = (9'd1 << n) - 9'd1;
            low_mask = (n >= 4'd8) ? 8'hFF : v[7:0];
        end
    endfunction

endpackage

// ===== src/ptgb_ctrl.sv =====
// Sequencing state machine for the glyph blitter.
module ptgb_ctrl
    import ptgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_req_type,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_req_type == REQ_HEADER) begin
                        o_cmd.load_hdr = 1'b1;
                        n_state        = S_MUL;
                    end else if (i_sts.glyph_active) begin
                        o_cmd.load_byte = 1'b1;
                        n_state         = S_RUN;
                    end
                end
            end
            S_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_state        = S_IDLE;
            end
            S_RUN: begin
                if (i_sts.chunk_ok) begin
                    o_cmd.emit = i_sts.out_free;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/ptgb_dp.sv =====
// Datapath: configuration, glyph geometry, bit buffer, chunk cutting and output register.
module ptgb_dp
    import ptgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [9:0]  i_pos_x,
    input  logic [9:0]  i_pos_y,
    input  logic [4:0]  i_glyph_width,
    input  logic [4:0]  i_glyph_height,
    input  logic [1:0]  i_plane_offset,
    input  logic [7:0]  i_font_byte,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic [7:0]  o_write_mask,
    output logic        o_glyph_done
);

    logic [15:0] r_base;
    logic [15:0] r_row_stride;
    logic [15:0] r_col_stride;
    logic [2:0]  r_col_shift;
    logic [2:0]  r_bpl;

    logic [9:0]  r_py;
    logic [10:0] r_xe;
    logic [1:0]  r_plane;
    logic [15:0] r_prod_row;
    logic [15:0] r_prod_col;

    logic [15:0] r_buf;
    logic [4:0]  r_bits;
    logic [15:0] r_line;
    logic [15:0] r_chunk;
    logic [3:0]  r_fcw;
    logic [2:0]  r_off;
    logic [4:0]  r_pl;
    logic [4:0]  r_lines;
    logic [4:0]  r_width;
    logic [1:0]  r_seen;
    logic        r_active;
    logic [CNT_W-1:0] r_cnt;

    logic        r_out_valid;
    logic [15:0] r_out_addr;
    logic [7:0]  r_out_data;
    logic [7:0]  r_out_mask;
    logic        r_out_done;

    logic [4:0]  w_w;
    logic [4:0]  w_h;
    logic [10:0] w_xe;
    logic [2:0]  w_off;
    logic [3:0]  w_fw;
    logic        w_first;
    logic [3:0]  w_cw;
    logic [7:0]  w_lm;
    logic [15:0] w_mask_wide;
    logic [15:0] w_data_wide;
    logic [7:0]  w_mask;
    logic [7:0]  w_data;
    logic [15:0] w_addr;
    logic [4:0]  w_pl_after;
    logic [4:0]  w_lines_after;
    logic [23:0] w_byte_shift;
    logic [25:0] w_prod_row;
    logic [26:0] w_prod_col;
    logic [10:0] w_col_idx;

    always_comb begin
        w_w = i_glyph_width;
        if (i_glyph_width == 5'd0) begin
            w_w = 5'd1;
        end else if (i_glyph_width > 5'(MAX_GLYPH_WIDTH)) begin
            w_w = 5'(MAX_GLYPH_WIDTH);
        end
        w_h = i_glyph_height;
        if (i_glyph_height == 5'd0) begin
            w_h = 5'd1;
        end else if (i_glyph_height > 5'(MAX_GLYPH_HEIGHT)) begin
            w_h = 5'(MAX_GLYPH_HEIGHT);
        end
        w_xe  = {1'b0, i_pos_x} + {6'd0, w_w} - 11'd1;
        w_off = ~w_xe[2:0];
        w_fw  = 4'd8 - {1'b0, w_off};
        if ({1'b0, w_fw} > w_w) begin
            w_fw = w_w[3:0];
        end
    end

    always_comb begin
        w_first = (r_pl == r_width);
        if (w_first) begin
            w_cw = r_fcw;
        end else if (r_pl < 5'd8) begin
            w_cw = r_pl[3:0];
        end else begin
            w_cw = 4'd8;
        end
        w_lm        = low_mask(w_cw);
        w_mask_wide = {8'h00, w_lm} << r_off;
        w_data_wide = {8'h00, r_buf[7:0]} << r_off;
        if (w_first) begin
            w_mask = w_mask_wide[7:0];
            w_data = w_data_wide[7:0] & w_mask_wide[7:0];
            w_addr = r_line;
        end else begin
            w_mask = w_lm;
            w_data = r_buf[7:0] & w_lm;
            w_addr = r_chunk;
        end
        w_pl_after    = r_pl - {1'b0, w_cw};
        w_lines_after = r_lines - 5'd1;
        w_byte_shift  = {16'h0000, i_font_byte} << r_bits;
        w_col_idx     = r_xe >> r_col_shift;
        w_prod_row    = r_py * r_row_stride;
        w_prod_col    = w_col_idx * r_col_stride;
    end

    assign o_sts.glyph_active = r_active;
    assign o_sts.chunk_ok     = (r_lines != 5'd0) && ({1'b0, w_cw} <= r_bits)
                                && (r_cnt != CNT_W'(MAX_WRITES));
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= 16'd0;
            r_row_stride <= 16'd2;
            r_col_stride <= 16'd256;
            r_col_shift  <= 3'd3;
            r_bpl        <= 3'd2;
            r_buf        <= '0;
            r_bits       <= '0;
            r_line       <= '0;
            r_chunk      <= '0;
            r_fcw        <= '0;
            r_off        <= '0;
            r_pl         <= '0;
            r_lines      <= '0;
            r_width      <= '0;
            r_seen       <= '0;
            r_active     <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE_ADDRESS:   r_base       <= i_cfg_data;
                    CFG_ROW_STRIDE:     r_row_stride <= i_cfg_data;
                    CFG_COLUMN_STRIDE:  r_col_stride <= i_cfg_data;
                    CFG_COLUMN_SHIFT:   r_col_shift  <= i_cfg_data[2:0];
                    CFG_BYTES_PER_LINE: r_bpl        <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.load_hdr) begin
                r_py     <= i_pos_y;
                r_xe     <= w_xe;
                r_plane  <= i_plane_offset;
                r_off    <= w_off;
                r_fcw    <= w_fw;
                r_width  <= w_w;
                r_pl     <= w_w;
                r_lines  <= w_h;
                r_buf    <= '0;
                r_bits   <= '0;
                r_seen   <= '0;
                r_active <= 1'b1;
            end

            if (i_cmd.calc_mul) begin
                r_prod_row <= w_prod_row[15:0];
                r_prod_col <= w_prod_col[15:0];
            end

            if (i_cmd.calc_sum) begin
                r_line  <= r_base + r_prod_row + r_prod_col + {14'd0, r_plane};
                r_chunk <= r_base + r_prod_row + r_prod_col + {14'd0, r_plane};
            end

            if (i_cmd.load_byte) begin
                r_buf  <= r_buf | w_byte_shift[15:0];
                r_bits <= r_bits + 5'd8;
                r_cnt  <= '0;
                if (r_seen != 2'd2) begin
                    r_seen <= r_seen + 2'd1;
                end
            end

            if (i_cmd.emit) begin
                r_chunk <= w_addr - r_col_stride;
                r_buf   <= r_buf >> w_cw;
                r_bits  <= r_bits - {1'b0, w_cw};
                r_cnt   <= r_cnt + CNT_W'(1);
                if (w_pl_after == 5'd0) begin
                    r_lines <= w_lines_after;
                    r_line  <= r_line + {13'd0, r_bpl};
                    r_pl    <= r_width;
                end else begin
                    r_pl <= w_pl_after;
                end
            end

            if (i_cmd.finish) begin
                if (r_lines == 5'd0 && r_seen == 2'd2) begin
                    r_active <= 1'b0;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_addr <= w_addr;
            r_out_data <= w_data;
            r_out_mask <= w_mask;
            r_out_done <= (w_pl_after == 5'd0) && (w_lines_after == 5'd0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_write_data    = r_out_data;
    assign o_write_mask    = r_out_mask;
    assign o_glyph_done    = r_out_done;

endmodule

// ===== src/planar_tile_glyph_blitter_core.sv =====
// Top level of the planar tile glyph blitter.
// A header transaction is accepted, then passes through S_MUL for the two address
// multiplies and S_SUM for the start-address sum. A font byte releases k
// masked writes, where k (0 to 8) is bounded by MAX_WRITES: accept, then
// each write through the single chunk unit in S_RUN, then a closing step;
// a write also waits while the output register is stalled. A data
// byte with no glyph active is accepted and dropped. Writes leave through a
// one-entry output register; configuration writes are always taken.
module planar_tile_glyph_blitter_core
    import ptgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [9:0]  i_pos_x,
    input  logic [9:0]  i_pos_y,
    input  logic [4:0]  i_glyph_width,
    input  logic [4:0]  i_glyph_height,
    input  logic [1:0]  i_plane_offset,
    input  logic [7:0]  i_font_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic [7:0]  o_write_mask,
    output logic        o_glyph_done
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ptgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    ptgb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_glyph_width   (i_glyph_width),
        .i_glyph_height  (i_glyph_height),
        .i_plane_offset  (i_plane_offset),
        .i_font_byte     (i_font_byte),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_write_mask    (o_write_mask),
        .o_glyph_done    (o_glyph_done)
    );

    a_hdr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type == REQ_HEADER)
            |=> o_in_stall ##1 o_in_stall)
        else $error("header transaction not held for address calculation");

    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type == REQ_DATA && !w_sts.glyph_active)
            |=> !o_in_stall)
        else $error("ignored font byte stalled the input");

    a_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("write produced while input was open");

endmodule

// ===== test/planar_tile_glyph_blitter_core_tb.sv =====
// Self-checking testbench for the planar tile glyph blitter core.
module planar_tile_glyph_blitter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptgb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PARK_CYCLES    = 200;
    localparam int PHASE_ITEMS    = 48;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [9:0] x;
        logic [9:0] y;
        logic [4:0] w;
        logic [4:0] h;
        logic [1:0] plane;
        logic [7:0] font;
    } blit_req_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  mask;
        logic        done;
    } tile_write_t;

    typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic [9:0]  i_pos_x = '0;
    logic [9:0]  i_pos_y = '0;
    logic [4:0]  i_glyph_width = '0;
    logic [4:0]  i_glyph_height = '0;
    logic [1:0]  i_plane_offset = '0;
    logic [7:0]  i_font_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_write_address;
    logic [7:0]  o_write_data;
    logic [7:0]  o_write_mask;
    logic        o_glyph_done;

    planar_tile_glyph_blitter_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_plane_offset (i_plane_offset),
        .i_font_byte    (i_font_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_write_address(o_write_address),
        .o_write_data   (o_write_data),
        .o_write_mask   (o_write_mask),
        .o_glyph_done   (o_glyph_done)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    blit_req_t   glyph_stream[$];
    tile_write_t pending_writes[$];
    int          stim_items = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    logic        park_rx = 1'b0;

    logic [15:0] cfg_base = 16'd0;
    logic [15:0] cfg_row_stride = 16'd2;
    logic [15:0] cfg_col_stride = 16'd256;
    logic [2:0]  cfg_col_shift = 3'd3;
    logic [2:0]  cfg_line_step = 3'd2;

    logic [15:0] m_bits = '0;
    logic [4:0]  m_held = '0;
    logic [15:0] m_line_addr = '0;
    logic [15:0] m_chunk_addr = '0;
    logic [3:0]  m_first_w = '0;
    logic [2:0]  m_first_off = '0;
    logic [4:0]  m_px_left = '0;
    logic [4:0]  m_rows_left = '0;
    logic [4:0]  m_width = '0;
    logic [1:0]  m_bytes = '0;
    logic        m_active = 1'b0;

    function automatic void predict_writes(input blit_req_t r);
        int unsigned w, h, xe, off, fw, cw, n;
        logic [31:0] sum;
        logic [15:0] shifted;
        logic [7:0]  mask;
        logic        lead;
        tile_write_t wr;
        if (r.kind == REQ_HEADER) begin
            w = r.w;
            h = r.h;
            if (w < 1) w = 1;
            if (w > MAX_GLYPH_WIDTH) w = MAX_GLYPH_WIDTH;
            if (h < 1) h = 1;
            if (h > MAX_GLYPH_HEIGHT) h = MAX_GLYPH_HEIGHT;
            xe = r.x + w - 1;
            sum = cfg_base + r.y * cfg_row_stride + (xe >> cfg_col_shift) * cfg_col_stride
                + r.plane;
            off = (xe & 7) ^ 7;
            fw = 8 - off;
            if (fw > w) fw = w;
            m_line_addr = sum[15:0];
            m_chunk_addr = sum[15:0];
            m_first_off = off[2:0];
            m_first_w = fw[3:0];
            m_width = w[4:0];
            m_px_left = w[4:0];
            m_rows_left = h[4:0];
            m_bits = '0;
            m_held = '0;
            m_bytes = '0;
            m_active = 1'b1;
        end else if (m_active) begin
            m_bits = m_bits | (16'(r.font) << m_held);
            m_held = m_held + 5'd8;
            if (m_bytes < 2) m_bytes = m_bytes + 2'd1;
            n = 0;
            while (m_rows_left > 0 && n < MAX_WRITES) begin
                lead = (m_px_left == m_width);
                cw = lead ? m_first_w : (m_px_left < 8 ? m_px_left : 8);
                if (m_held < cw) break;
                mask = (cw >= 8) ? 8'hFF : 8'((1 << cw) - 1);
                if (lead) begin
                    mask = mask << m_first_off;
                    shifted = m_bits << m_first_off;
                    wr.data = shifted[7:0] & mask;
                    wr.addr = m_line_addr;
                    m_chunk_addr = m_line_addr - cfg_col_stride;
                end else begin
                    wr.data = m_bits[7:0] & mask;
                    wr.addr = m_chunk_addr;
                    m_chunk_addr = m_chunk_addr - cfg_col_stride;
                end
                wr.mask = mask;
                wr.done = 1'b0;
                m_bits = m_bits >> cw;
                m_held = m_held - cw[4:0];
                m_px_left = m_px_left - cw[4:0];
                if (m_px_left == 0) begin
                    m_rows_left = m_rows_left - 5'd1;
                    m_line_addr = m_line_addr + {13'd0, cfg_line_step};
                    m_px_left = m_width;
                    if (m_rows_left == 0) wr.done = 1'b1;
                end
                pending_writes.push_back(wr);
                n++;
            end
            if (m_rows_left == 0 && m_bytes >= 2) m_active = 1'b0;
        end
    endfunction

    task automatic push_header(input int x, input int y, input int w, input int h,
                               input int plane);
        blit_req_t r;
        r.kind = REQ_HEADER;
        r.x = x[9:0];
        r.y = y[9:0];
        r.w = w[4:0];
        r.h = h[4:0];
        r.plane = plane[1:0];
        r.font = 8'($urandom_range(0, 255));
        glyph_stream.push_back(r);
        stim_items++;
    endtask

    task automatic push_byte(input logic [7:0] b, input bit counted);
        blit_req_t r;
        r.kind = REQ_DATA;
        r.x = 10'($urandom_range(0, 1023));
        r.y = 10'($urandom_range(0, 1023));
        r.w = 5'($urandom_range(0, 31));
        r.h = 5'($urandom_range(0, 31));
        r.plane = 2'($urandom_range(0, 3));
        r.font = b;
        glyph_stream.push_back(r);
        if (counted) stim_items++;
    endtask

    task automatic queue_random_glyph();
        int unsigned w, h, we, he, nbytes, sel;
        sel = $urandom_range(0, 19);
        w = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(17, 31) :
            (sel < 5) ? $urandom_range(11, 16) : $urandom_range(1, 10);
        sel = $urandom_range(0, 19);
        h = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(17, 31) :
            (sel < 4) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        we = (w < 1) ? 1 : (w > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : w;
        he = (h < 1) ? 1 : (h > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : h;
        nbytes = (we * he + 7) / 8;
        if (nbytes < 2) nbytes = 2;
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_header($urandom_range(0, 1023), $urandom_range(0, 1023), w, h,
                    $urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel == 0) nbytes = $urandom_range(0, nbytes - 1);
        repeat (nbytes) push_byte(8'($urandom_range(0, 255)), 1'b1);
        if (sel == 1) repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE_ADDRESS:   cfg_base = value;
            CFG_ROW_STRIDE:     cfg_row_stride = value;
            CFG_COLUMN_STRIDE:  cfg_col_stride = value;
            CFG_COLUMN_SHIFT:   cfg_col_shift = value[2:0];
            CFG_BYTES_PER_LINE: cfg_line_step = value[2:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (glyph_stream.size() != 0 || i_in_valid || pending_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = stim_items + count;
        while (stim_items < goal) queue_random_glyph();
    endtask

    // driver
    blit_req_t cur_req = '0;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_writes(cur_req);
                busy = 1'b0;
            end
            if (!busy && gap_left > 0) begin
                gap_left--;
            end else if (!busy && glyph_stream.size() > 0) begin
                cur_req = glyph_stream.pop_front();
                busy = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            i_in_valid     <= busy;
            i_req_type     <= cur_req.kind;
            i_pos_x        <= cur_req.x;
            i_pos_y        <= cur_req.y;
            i_glyph_width  <= cur_req.w;
            i_glyph_height <= cur_req.h;
            i_plane_offset <= cur_req.plane;
            i_font_byte    <= cur_req.font;
        end
    end

    // receiver stall pattern
    rx_mode_t rx_mode = RX_FLOW;
    int       rx_mode_left = 0;
    int       rx_tick = 0;
    int       park_cnt = 0;

    always @(posedge i_clk) begin
        logic hold;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(10, 80);
            end else begin
                rx_mode_left--;
            end
            if (park_rx && park_cnt < PARK_CYCLES) begin
                park_cnt++;
                hold = 1'b1;
            end else begin
                case (rx_mode)
                    RX_FLOW:  hold = 1'b0;
                    RX_LIGHT: hold = ($urandom_range(0, 3) == 0);
                    RX_HEAVY: hold = ($urandom_range(0, 9) < 6);
                    default:  hold = ((rx_tick % 5) < 2);
                endcase
            end
            i_out_stall <= hold;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        tile_write_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected write: addr %h data %h mask %h done %b",
                             o_write_address, o_write_data, o_write_mask, o_glyph_done);
            end else begin
                want = pending_writes.pop_front();
                if (o_write_address !== want.addr || o_write_data !== want.data ||
                    o_write_mask !== want.mask || o_glyph_done !== want.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("write mismatch: expected addr %h data %h mask %h done %b, got addr %h data %h mask %h done %b",
                                 want.addr, want.data, want.mask, want.done,
                                 o_write_address, o_write_data, o_write_mask, o_glyph_done);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_byte(8'hFF, 1'b1);
        push_header(0, 0, 1, 1, 0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_header(1023, 1023, 16, 1, 3);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b1);
        push_header(5, 7, 0, 0, 1);
        push_byte(8'h01, 1'b1);
        push_byte(8'hFE, 1'b1);
        push_header(9, 2, 31, 1, 2);
        push_byte(8'h3C, 1'b1);
        push_byte(8'hC3, 1'b1);
        push_header(300, 400, 1, 31, 0);
        push_byte(8'h55, 1'b1);
        push_byte(8'hAA, 1'b1);
        // drop a glyph midway with a new header
        push_header(12, 3, 8, 2, 1);
        push_byte(8'hF0, 1'b1);
        push_header(6, 0, 3, 3, 2);
        push_byte(8'h96, 1'b1);
        push_byte(8'h69, 1'b1);
        drain();

        write_register(CFG_BASE_ADDRESS, 16'h0000);
        write_register(CFG_ROW_STRIDE, 16'h0000);
        write_register(CFG_COLUMN_STRIDE, 16'h0000);
        write_register(CFG_COLUMN_SHIFT, 16'h0000);
        write_register(CFG_BYTES_PER_LINE, 16'h0000);
        run_random(PHASE_ITEMS);
        drain();

        write_register(CFG_BASE_ADDRESS, 16'hFFFF);
        write_register(CFG_ROW_STRIDE, 16'hFFFF);
        write_register(CFG_COLUMN_STRIDE, 16'hFFFF);
        write_register(CFG_COLUMN_SHIFT, 16'hFFFF);
        write_register(CFG_BYTES_PER_LINE, 16'hFFFF);
        write_register(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        run_random(PHASE_ITEMS);
        drain();

        write_register(CFG_BASE_ADDRESS, 16'($urandom_range(0, 65535)));
        write_register(CFG_ROW_STRIDE, 16'($urandom_range(0, 65535)));
        write_register(CFG_COLUMN_STRIDE, 16'($urandom_range(0, 65535)));
        write_register(CFG_COLUMN_SHIFT, 16'($urandom_range(0, 65535)));
        write_register(CFG_BYTES_PER_LINE, 16'($urandom_range(0, 65535)));
        run_random(PHASE_ITEMS);
        park_rx = 1'b1;
        drain();

        write_register(CFG_BASE_ADDRESS, 16'($urandom_range(0, 65535)));
        write_register(CFG_ROW_STRIDE, 16'd2);
        write_register(CFG_COLUMN_STRIDE, 16'd32);
        write_register(CFG_COLUMN_SHIFT, 16'd3);
        write_register(CFG_BYTES_PER_LINE, 16'($urandom_range(1, 4)));
        run_random(PHASE_ITEMS);
        drain();

        if (pending_writes.size() != 0) begin
            mismatches += pending_writes.size();
            $display("%0d expected writes never arrived", pending_writes.size());
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
